// ----- rtl/sbu_pkg.sv -----
// Shared types and constants for the selective background update core.
package sbu_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 8;
  localparam int DIV_W      = PIX_W + 1;
  localparam int DIFF_SCALE = 2;
  localparam int NUM_CELLS  = PIX_W;

  localparam logic [CFG_W-1:0] BG_DIV_RESET = CFG_W'(4);
  localparam logic [CFG_W-1:0] FG_DIV_RESET = CFG_W'(16);

  typedef enum logic [0:0] {
    REG_BG_DIV = 1'b0,
    REG_FG_DIV = 1'b1
  } cfg_reg_t;

  // Data that one pixel carries down the divider chain.
  // acc starts as the dividend and fills with quotient bits from the bottom.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [PIX_W-1:0] acc;
    logic [DIV_W-1:0] divisor;
    logic [PIX_W-1:0] base;
    logic             add;
    logic             sof;
    logic             eol;
  } sbu_cell_t;

  typedef struct packed {
    logic skid_full;
  } sbu_out_status_t;

endpackage

// ----- rtl/selective_background_update_core.sv -----
// Top level of the selective background update core: config registers and the divider chain.
//
//  Channel  | Ports                                             | Handshake
//  ---------+---------------------------------------------------+----------------------------
//  input    | in_frame_pixel, in_seg_mask, in_background_pixel, | in_valid / in_stall
//           | in_start_of_frame, in_end_of_line                 |
//  result   | out_new_background, out_frame_start_out,          | out_valid / out_stall
//           | out_line_end_out                                  |
//  config   | cfg_index, cfg_data                               | cfg_we, no wait
//
// One pixel request is accepted every cycle while in_stall is low; its result reaches the outputs
// after the front stage captures it at the accepting edge and it passes through the eight divider cells
// and one output register.
// Each of the eight division cells in the chain produces one quotient bit.
// Reset is synchronous and active low; divisors return to 4 and 16.
// A stalled result parks in a skid register; only when it is full does in_stall rise.
module selective_background_update_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [sbu_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sbu_pkg::PIX_W-1:0]   in_frame_pixel,
  input  logic [sbu_pkg::PIX_W-1:0]   in_seg_mask,
  input  logic [sbu_pkg::PIX_W-1:0]   in_background_pixel,
  input  logic                        in_start_of_frame,
  input  logic                        in_end_of_line,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sbu_pkg::PIX_W-1:0]   out_new_background,
  output logic                        out_frame_start_out,
  output logic                        out_line_end_out
);
  import sbu_pkg::*;

  logic [CFG_W-1:0] bg_div_r;
  logic [CFG_W-1:0] fg_div_r;
  logic             advance;
  sbu_out_status_t  status;

  logic             chain_valid [NUM_CELLS+1];
  sbu_cell_t        chain_data  [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_div_r <= BG_DIV_RESET;
      fg_div_r <= FG_DIV_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BG_DIV: bg_div_r <= cfg_data;
        REG_FG_DIV: fg_div_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sbu_prep u_prep (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .in_valid         (in_valid),
    .frame_pixel      (in_frame_pixel),
    .seg_mask         (in_seg_mask),
    .background_pixel (in_background_pixel),
    .start_of_frame   (in_start_of_frame),
    .end_of_line      (in_end_of_line),
    .bg_div           (bg_div_r),
    .fg_div           (fg_div_r),
    .valid_out        (chain_valid[0]),
    .data_out         (chain_data[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sbu_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .valid_in  (chain_valid[i]),
      .data_in   (chain_data[i]),
      .valid_out (chain_valid[i+1]),
      .data_out  (chain_data[i+1])
    );
  end

  sbu_out u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .valid_in            (chain_valid[NUM_CELLS]),
    .data_in             (chain_data[NUM_CELLS]),
    .advance             (advance),
    .status              (status),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_new_background  (out_new_background),
    .out_frame_start_out (out_frame_start_out),
    .out_line_end_out    (out_line_end_out)
  );

  assign in_stall = !advance;

  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    status.skid_full |-> out_valid)
    else $error("skid register holds a result while the output is empty");

  // Once the output is taken, the skid register drains into it.
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    status.skid_full && !out_stall |=> !status.skid_full && out_valid)
    else $error("skid register did not drain after the output was taken");

  // The chain holds still while the skid register is full.
  a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    status.skid_full |=> $stable(chain_valid[NUM_CELLS]))
    else $error("divider chain moved while the skid register was full");

endmodule

// ----- rtl/sbu_prep.sv -----
// Front stage: picks the divisor, forms the difference magnitude and the update direction.
module sbu_prep (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic                    in_valid,
  input  logic [sbu_pkg::PIX_W-1:0] frame_pixel,
  input  logic [sbu_pkg::PIX_W-1:0] seg_mask,
  input  logic [sbu_pkg::PIX_W-1:0] background_pixel,
  input  logic                    start_of_frame,
  input  logic                    end_of_line,
  input  logic [sbu_pkg::CFG_W-1:0] bg_div,
  input  logic [sbu_pkg::CFG_W-1:0] fg_div,
  output logic                    valid_out,
  output sbu_pkg::sbu_cell_t      data_out
);
  import sbu_pkg::*;

  logic             valid_r;
  sbu_cell_t        data_r;
  sbu_cell_t        data_nxt;
  logic             is_bg;
  logic             f_gt_b;
  logic [CFG_W-1:0] raw_div;
  logic [DIV_W-1:0] eff_div;

  always_comb begin
    is_bg   = (seg_mask == '0);
    f_gt_b  = (frame_pixel > background_pixel);
    raw_div = is_bg ? bg_div : fg_div;
    // A zero divisor behaves as one.
    eff_div = (raw_div == '0) ? DIV_W'(1) : DIV_W'(raw_div);

    data_nxt.rem     = '0;
    data_nxt.acc     = f_gt_b ? (frame_pixel - background_pixel)
                              : (background_pixel - frame_pixel);
    data_nxt.divisor = f_gt_b ? DIV_W'(eff_div * DIV_W'(DIFF_SCALE)) : eff_div;
    data_nxt.base    = is_bg ? frame_pixel : background_pixel;
    // Background steps from the frame back toward the old background; foreground creeps toward the frame.
    data_nxt.add     = is_bg ? !f_gt_b : f_gt_b;
    data_nxt.sof     = start_of_frame;
    data_nxt.eol     = end_of_line;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

// ----- rtl/sbu_div_cell.sv -----
// One restoring-division cell: produces one quotient bit and passes the pixel on.
module sbu_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               valid_in,
  input  sbu_pkg::sbu_cell_t data_in,
  output logic               valid_out,
  output sbu_pkg::sbu_cell_t data_out
);
  import sbu_pkg::*;

  logic             valid_r;
  sbu_cell_t        data_r;
  sbu_cell_t        data_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {data_in.rem, data_in.acc[PIX_W-1]};
    rem_sub = rem_sh - {1'b0, data_in.divisor};
    ge      = (rem_sh >= {1'b0, data_in.divisor});

    data_nxt     = data_in;
    data_nxt.rem = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    data_nxt.acc = {data_in.acc[PIX_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

// ----- rtl/sbu_out.sv -----
// Output stage: applies the quotient to the base value and holds the result with a skid register.
module sbu_out (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_in,
  input  sbu_pkg::sbu_cell_t        data_in,
  output logic                      advance,
  output sbu_pkg::sbu_out_status_t  status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [sbu_pkg::PIX_W-1:0] out_new_background,
  output logic                      out_frame_start_out,
  output logic                      out_line_end_out
);
  import sbu_pkg::*;

  logic             out_valid_r;
  logic [PIX_W-1:0] bg_r;
  logic             sof_r;
  logic             eol_r;
  logic             skid_valid_r;
  logic [PIX_W-1:0] skid_bg_r;
  logic             skid_sof_r;
  logic             skid_eol_r;
  logic [PIX_W-1:0] bg_nxt;
  logic             out_free;

  // The result always lies between frame and background, so 8-bit wrap is safe.
  assign bg_nxt   = data_in.add ? (data_in.base + data_in.acc)
                                : (data_in.base - data_in.acc);
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= valid_in;
      end
    end else if (valid_in && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        bg_r  <= skid_bg_r;
        sof_r <= skid_sof_r;
        eol_r <= skid_eol_r;
      end else if (valid_in) begin
        bg_r  <= bg_nxt;
        sof_r <= data_in.sof;
        eol_r <= data_in.eol;
      end
    end else if (valid_in && !skid_valid_r) begin
      skid_bg_r  <= bg_nxt;
      skid_sof_r <= data_in.sof;
      skid_eol_r <= data_in.eol;
    end
  end

  assign status.skid_full    = skid_valid_r;
  assign out_valid           = out_valid_r;
  assign out_new_background  = bg_r;
  assign out_frame_start_out = sof_r;
  assign out_line_end_out    = eol_r;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the selective background update core.
`timescale 1ns / 1ps

module tb_top;
  import sbu_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] frame;
    logic [PIX_W-1:0] mask;
    logic [PIX_W-1:0] bg;
    logic             sof;
    logic             eol;
  } pixel_req_t;

  typedef struct {
    logic [PIX_W-1:0] new_bg;
    logic             sof;
    logic             eol;
  } bg_result_t;

  typedef enum int {
    STALL_NEVER,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_frame_pixel = '0;
  logic [PIX_W-1:0] in_seg_mask = '0;
  logic [PIX_W-1:0] in_background_pixel = '0;
  logic             in_start_of_frame = 1'b0;
  logic             in_end_of_line = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_new_background;
  logic             out_frame_start_out;
  logic             out_line_end_out;

  // Divisor copies used for prediction; updated only while the core is idle.
  logic [CFG_W-1:0] bg_div;
  logic [CFG_W-1:0] fg_div;

  pixel_req_t pending_pixels[$];
  bg_result_t expected_bg[$];
  pixel_req_t next_pixel;
  bg_result_t want;

  logic        req_taken = 1'b0;
  int          accepted_total = 0;
  int          errors = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NEVER;
  int          stretch_left = 0;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;

  selective_background_update_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_frame_pixel      (in_frame_pixel),
    .in_seg_mask         (in_seg_mask),
    .in_background_pixel (in_background_pixel),
    .in_start_of_frame   (in_start_of_frame),
    .in_end_of_line      (in_end_of_line),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_new_background  (out_new_background),
    .out_frame_start_out (out_frame_start_out),
    .out_line_end_out    (out_line_end_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Background pixels move toward the frame faster than foreground pixels creep.
  function automatic logic [PIX_W-1:0] blend_background(logic [PIX_W-1:0] f,
                                                        logic [PIX_W-1:0] m,
                                                        logic [PIX_W-1:0] b);
    int fi;
    int bi;
    int d;
    int r;
    fi = f;
    bi = b;
    r = bi;
    if (m == '0) begin
      d = (bg_div == '0) ? 1 : int'(bg_div);
      if (fi > bi) r = fi - (fi - bi) / (DIFF_SCALE * d);
      else if (fi < bi) r = fi + (bi - fi) / d;
    end else begin
      d = (fg_div == '0) ? 1 : int'(fg_div);
      if (fi > bi) r = bi + (fi - bi) / (DIFF_SCALE * d);
      else if (fi < bi) r = bi - (bi - fi) / d;
    end
    return PIX_W'(r);
  endfunction

  // Sender: bursts of requests with random gaps; a stalled request is held.
  always @(negedge clk) begin
    if (in_valid && !req_taken) begin
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_pixels.size() > 0) begin
      next_pixel = pending_pixels.pop_front();
      in_frame_pixel      <= next_pixel.frame;
      in_seg_mask         <= next_pixel.mask;
      in_background_pixel <= next_pixel.bg;
      in_start_of_frame   <= next_pixel.sof;
      in_end_of_line      <= next_pixel.eol;
      in_valid            <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 48);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern, plus one long hold-off once traffic is flowing.
  always @(negedge clk) begin
    if (!long_hold_done && accepted_total >= 400) begin
      long_hold_done <= 1'b1;
      hold_left      <= 80;
      out_stall      <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stall_mode   <= stall_mode_t'($urandom_range(0, 3));
        stretch_left <= $urandom_range(5, 60);
        if ($urandom_range(0, 39) == 0) hold_left <= $urandom_range(20, 50);
      end else begin
        stretch_left <= stretch_left - 1;
      end
      case (stall_mode)
        STALL_NEVER:    out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        default:        out_stall <= (stretch_left % 3 == 0);
      endcase
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        want.new_bg = blend_background(in_frame_pixel, in_seg_mask, in_background_pixel);
        want.sof    = in_start_of_frame;
        want.eol    = in_end_of_line;
        expected_bg.push_back(want);
        accepted_total <= accepted_total + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_bg.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result: expected none, actual bg=%0d sof=%0b eol=%0b",
                   $time, out_new_background, out_frame_start_out, out_line_end_out);
        end else begin
          want = expected_bg.pop_front();
          if (out_new_background !== want.new_bg) begin
            errors = errors + 1;
            $display("%0t: new_background mismatch: expected %0d, actual %0d",
                     $time, want.new_bg, out_new_background);
          end
          if (out_frame_start_out !== want.sof) begin
            errors = errors + 1;
            $display("%0t: frame_start_out mismatch: expected %0b, actual %0b",
                     $time, want.sof, out_frame_start_out);
          end
          if (out_line_end_out !== want.eol) begin
            errors = errors + 1;
            $display("%0t: line_end_out mismatch: expected %0b, actual %0b",
                     $time, want.eol, out_line_end_out);
          end
        end
      end
    end
  end

  task automatic add_pixel(int f, int m, int b, bit sof, bit eol);
    pixel_req_t p;
    p.frame = PIX_W'(f);
    p.mask  = PIX_W'(m);
    p.bg    = PIX_W'(b);
    p.sof   = sof;
    p.eol   = eol;
    pending_pixels.push_back(p);
  endtask

  task automatic add_random_pixels(int n);
    int kind;
    int f;
    int b;
    int m;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      f = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      if (kind == 5 || kind == 6) begin
        b = f + $urandom_range(0, 8) - 4;
        if (b < 0) b = 0;
        if (b > 255) b = 255;
      end else if (kind == 7) begin
        b = f;
      end else if (kind >= 8) begin
        f = $urandom_range(0, 1) * 255;
        b = $urandom_range(0, 1) * 255;
      end
      m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 255);
      add_pixel(f, m, b, $urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic write_divisor(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BG_DIV) bg_div = val;
    else fg_div = val;
  endtask

  // Returns once every queued request has been taken and every result checked.
  task automatic wait_idle();
    while (pending_pixels.size() > 0 || in_valid || expected_bg.size() > 0)
      @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    bg_div = BG_DIV_RESET;
    fg_div = FG_DIV_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes of each field, both mask classes, equal pixels and flag combinations.
    add_pixel(255, 0, 0, 1'b1, 1'b0);
    add_pixel(0, 0, 255, 1'b0, 1'b1);
    add_pixel(255, 1, 0, 1'b1, 1'b1);
    add_pixel(0, 255, 255, 1'b0, 1'b0);
    add_pixel(0, 0, 0, 1'b0, 1'b0);
    add_pixel(255, 0, 255, 1'b1, 1'b0);
    add_pixel(128, 128, 128, 1'b0, 1'b1);
    add_pixel(17, 0, 18, 1'b0, 1'b0);
    add_pixel(18, 0, 17, 1'b0, 1'b0);
    add_pixel(100, 64, 101, 1'b0, 1'b0);
    add_pixel(101, 64, 100, 1'b0, 1'b0);
    add_pixel(200, 0, 50, 1'b0, 1'b1);
    add_pixel(50, 0, 200, 1'b1, 1'b0);
    add_pixel(200, 170, 50, 1'b0, 1'b0);
    add_pixel(50, 85, 200, 1'b0, 1'b1);
    add_pixel(170, 0, 85, 1'b1, 1'b1);
    add_pixel(85, 2, 170, 1'b0, 1'b0);
    add_random_pixels(100);
    wait_idle();

    // Divisor sweep: unit, maximum, zero (treated as one), mixed, then random.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_divisor(REG_BG_DIV, 8'd1);   write_divisor(REG_FG_DIV, 8'd1);   end
        1: begin write_divisor(REG_BG_DIV, 8'd255); write_divisor(REG_FG_DIV, 8'd255); end
        2: begin write_divisor(REG_BG_DIV, 8'd0);   write_divisor(REG_FG_DIV, 8'd0);   end
        3: begin write_divisor(REG_BG_DIV, 8'd2);   write_divisor(REG_FG_DIV, 8'd128); end
        4: begin write_divisor(REG_BG_DIV, 8'd255); write_divisor(REG_FG_DIV, 8'd1);   end
        5: begin write_divisor(REG_BG_DIV, 8'd3);   write_divisor(REG_FG_DIV, 8'd5);   end
        default: begin
          write_divisor(REG_BG_DIV, CFG_W'($urandom_range(0, 255)));
          write_divisor(REG_FG_DIV, CFG_W'($urandom_range(0, 255)));
        end
      endcase
      add_random_pixels(140);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (errors == 0 && expected_bg.size() == 0) begin
      $display("selective_background_update_core verification clean");
    end else begin
      $display("selective_background_update_core verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("selective_background_update_core verification failed");
    $finish;
  end

endmodule
